// File: rtl/spq_pkg.sv
// spq_pkg: shared types, codes and constants of the servo teach and replay block
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package spq_pkg;

  localparam int ACTION_W  = 2;
  localparam int CH_W      = 3;
  localparam int READING_W = 10;
  localparam int SLOT_W    = 2;
  localparam int DUTY_W    = 7;
  localparam int DWELL_W   = 16;
  localparam int PROD_W    = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DWELL_W-1:0]   DWELL_RESET  = 16'd1500;
  localparam logic [PROD_W-1:0]    READING_FULL = 16'd1023;

  // item action codes
  localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RECORD = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

  localparam logic MODE_AUTO = 1'b1;

  // per-channel scale and offset of the duty map
  localparam logic [6:0] CHAN_SCALE [5] = '{7'd60, 7'd30, 7'd30, 7'd15, 7'd30};
  localparam logic [6:0] CHAN_OFFSET[5] = '{7'd17, 7'd17, 7'd17, 7'd32, 7'd32};

  typedef enum logic [1:0] {
    CMD_SAMPLE,
    CMD_RECORD,
    CMD_REPLAY
  } spq_cmd_e;

  typedef struct packed {
    spq_cmd_e               kind;
    logic [CH_W-1:0]        ch;
    logic [READING_W-1:0]   reading;
    logic [SLOT_W-1:0]      slot;
  } spq_cmd_t;

  // floor(prod / 1023): estimate by a shift, then one compare and correct
  function automatic logic [DUTY_W-1:0] div_full(input logic [PROD_W-1:0] prod);
    logic [5:0]        q0;
    logic [PROD_W-1:0] base;
    logic [PROD_W-1:0] rem;
    q0   = prod[PROD_W-1:10];
    base = {q0, 10'b0} - PROD_W'(q0);
    rem  = prod - base;
    div_full = (rem >= READING_FULL) ? DUTY_W'(q0) + DUTY_W'(1) : DUTY_W'(q0);
  endfunction

endpackage

`default_nettype wire

// File: rtl/spq_if.sv
// spq_if: valid/ready channel interfaces for items, results and the dwell register
// depends on spq_pkg
`default_nettype none

interface spq_in_if;
  import spq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic                 mode;
  logic [CH_W-1:0]      channel;
  logic [READING_W-1:0] reading;
  logic [SLOT_W-1:0]    button;
  modport source (output valid, action, mode, channel, reading, button, input ready);
  modport sink   (input valid, action, mode, channel, reading, button, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   servo;
  logic [DUTY_W-1:0] duty;
  logic              last;
  modport source (output valid, servo, duty, last, input ready);
  modport sink   (input valid, servo, duty, last, output ready);
endinterface

interface spq_cfg_if;
  import spq_pkg::*;
  logic               valid;
  logic               ready;
  logic [DWELL_W-1:0] dwell_ticks;
  modport source (output valid, dwell_ticks, input ready);
  modport sink   (input valid, dwell_ticks, output ready);
endinterface

`default_nettype wire

// File: rtl/spq_queue.sv
// spq_queue: two-entry command queue between the front and the back
// depends on spq_pkg
`default_nettype none

module spq_queue (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  spq_pkg::spq_cmd_t  push_cmd_i,
  output logic               full_o,
  input  wire                pop_i,
  output logic               valid_o,
  output spq_pkg::spq_cmd_t  head_o
);
  import spq_pkg::*;

  spq_cmd_t  entry_q [QUEUE_DEPTH];
  logic      wr_ptr_q, wr_ptr_d;
  logic      rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'(QUEUE_DEPTH));
  assign valid_o = (count_q != 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/spq_front.sv
// spq_front: takes items and dwell writes, keeps mode, record and replay state,
// and turns each item into at most one command; depends on spq_pkg, spq_if
`default_nettype none

module spq_front #(
  parameter int SERVO_COUNT = 5,
  parameter int POSE_SLOTS  = 4
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  spq_in_if.sink             in_if,
  spq_cfg_if.sink            cfg_if,
  input  wire                full_i,
  output logic               push_o,
  output spq_pkg::spq_cmd_t  cmd_o
);
  import spq_pkg::*;

  localparam int PW = (POSE_SLOTS > 1) ? $clog2(POSE_SLOTS) : 1;
  localparam int CW = $clog2(POSE_SLOTS + 1);

  logic                  rec_en_q, rec_en_d;
  logic [POSE_SLOTS-1:0] recorded_q, recorded_d;
  logic [PW-1:0]         play_q, play_d;
  logic [DWELL_W-1:0]    dwell_q, dwell_d;
  logic [DWELL_W-1:0]    dwell_ticks_q;

  logic                  accept;
  logic [POSE_SLOTS:0]   prev_ok;
  logic                  rec_ok;
  logic                  in_range;
  logic [CW-1:0]         cnt;
  logic                  run;
  logic [PW-1:0]         idx;
  logic [PW-1:0]         nxt;
  logic [DWELL_W:0]      dwell_n;
  logic [DWELL_W-1:0]    lim;

  assign in_if.ready  = !full_i;
  assign cfg_if.ready = 1'b1;
  assign accept       = in_if.valid && !full_i;
  assign prev_ok      = {recorded_q, 1'b1};

  always_comb begin
    rec_en_d   = rec_en_q;
    recorded_d = recorded_q;
    play_d     = play_q;
    dwell_d    = dwell_q;
    push_o     = 1'b0;
    cmd_o      = '{kind: CMD_SAMPLE, ch: in_if.channel, reading: in_if.reading,
                   slot: in_if.button};
    // length of the recorded prefix
    cnt = '0;
    run = 1'b1;
    for (int i = 0; i < POSE_SLOTS; i++) begin
      if (run && recorded_q[i]) begin
        cnt = cnt + CW'(1);
      end else begin
        run = 1'b0;
      end
    end
    // slot k needs the enable and slot k-1 already taken
    rec_ok   = 1'b0;
    in_range = 1'b0;
    for (int i = 0; i < POSE_SLOTS; i++) begin
      if (in_if.button == SLOT_W'(i)) begin
        rec_ok   = prev_ok[i];
        in_range = 1'b1;
      end
    end
    idx     = ({1'b0, play_q} >= (PW+1)'(cnt)) ? '0 : play_q;
    nxt     = ((PW+1)'(idx) + (PW+1)'(1) >= (PW+1)'(cnt)) ? '0 : idx + PW'(1);
    dwell_n = {1'b0, dwell_q} + (DWELL_W+1)'(1);
    lim     = (dwell_ticks_q == '0) ? DWELL_W'(1) : dwell_ticks_q;

    if (accept) begin
      unique case (in_if.action)
        ACT_RECORD: begin
          if (in_range && rec_ok && rec_en_q) begin
            for (int i = 0; i < POSE_SLOTS; i++) begin
              if (in_if.button == SLOT_W'(i)) begin
                recorded_d[i] = 1'b1;
              end
            end
            push_o     = 1'b1;
            cmd_o.kind = CMD_RECORD;
          end
        end
        ACT_SAMPLE, ACT_TICK: begin
          rec_en_d = (in_if.mode != MODE_AUTO);
          if (in_if.mode != MODE_AUTO) begin
            play_d  = '0;
            dwell_d = '0;
            if (in_if.action == ACT_SAMPLE && int'(in_if.channel) < SERVO_COUNT) begin
              push_o     = 1'b1;
              cmd_o.kind = CMD_SAMPLE;
            end
          end else if (in_if.action == ACT_TICK && cnt != '0) begin
            if (dwell_q == '0) begin
              push_o     = 1'b1;
              cmd_o.kind = CMD_REPLAY;
              cmd_o.slot = SLOT_W'(idx);
            end
            if (dwell_n >= (DWELL_W+1)'(lim)) begin
              dwell_d = '0;
              play_d  = nxt;
            end else begin
              dwell_d = dwell_n[DWELL_W-1:0];
              play_d  = idx;
            end
          end
        end
        ACT_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_en_q      <= 1'b0;
      recorded_q    <= '0;
      play_q        <= '0;
      dwell_q       <= '0;
      dwell_ticks_q <= DWELL_RESET;
    end else begin
      rec_en_q   <= rec_en_d;
      recorded_q <= recorded_d;
      play_q     <= play_d;
      dwell_q    <= dwell_d;
      if (cfg_if.valid) begin
        dwell_ticks_q <= cfg_if.dwell_ticks;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/spq_back.sv
// spq_back: carries out commands: live readings, pose memory, duty pipeline
// and the result register; depends on spq_pkg, spq_if
`default_nettype none

module spq_back #(
  parameter int SERVO_COUNT = 5,
  parameter int POSE_SLOTS  = 4
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cmd_valid_i,
  input  spq_pkg::spq_cmd_t  cmd_i,
  output logic               pop_o,
  spq_out_if.source          out_if
);
  import spq_pkg::*;

  localparam int JW    = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
  localparam int DEPTH = SERVO_COUNT * POSE_SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [READING_W-1:0] live_q [SERVO_COUNT];
  logic [READING_W-1:0] pose_mem [DEPTH];
  logic [READING_W-1:0] mem_rd_q;

  logic                 busy_q;
  spq_cmd_t             cmd_q;
  logic [JW-1:0]        j_q;

  logic                 adv;
  logic                 step;
  logic                 last_step;
  logic [AW-1:0]        addr;

  logic                 s1_valid_q;
  logic [CH_W-1:0]      s1_ch_q;
  logic                 s1_last_q;
  logic                 s1_mem_q;
  logic [READING_W-1:0] s1_reading_q;
  logic [READING_W-1:0] s1_rd;
  logic [PROD_W-1:0]    s1_prod;

  logic                 s2_valid_q;
  logic [CH_W-1:0]      s2_ch_q;
  logic                 s2_last_q;
  logic [PROD_W-1:0]    s2_prod_q;

  logic                 out_valid_q;
  logic [CH_W-1:0]      out_servo_q;
  logic [DUTY_W-1:0]    out_duty_q;
  logic                 out_last_q;

  // whole pipe moves unless the result register is held
  assign adv       = !out_valid_q || out_if.ready;
  assign pop_o     = !busy_q && cmd_valid_i;
  assign step      = busy_q && adv;
  assign last_step = (cmd_q.kind == CMD_SAMPLE) || (j_q == JW'(SERVO_COUNT - 1));
  assign addr      = AW'(int'(cmd_q.slot) * SERVO_COUNT + int'(j_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      j_q    <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      j_q    <= '0;
    end else if (step) begin
      if (last_step) begin
        busy_q <= 1'b0;
      end else begin
        j_q <= j_q + JW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SERVO_COUNT; i++) begin
        live_q[i] <= '0;
      end
    end else if (step && cmd_q.kind == CMD_SAMPLE) begin
      for (int i = 0; i < SERVO_COUNT; i++) begin
        if (cmd_q.ch == CH_W'(i)) begin
          live_q[i] <= cmd_q.reading;
        end
      end
    end
  end

  // pose memory: one write port for recording, one registered read port
  always_ff @(posedge clk_i) begin
    if (step && cmd_q.kind == CMD_RECORD) begin
      pose_mem[addr] <= live_q[j_q];
    end
    if (adv) begin
      mem_rd_q <= pose_mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= step && (cmd_q.kind == CMD_SAMPLE || cmd_q.kind == CMD_REPLAY);
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_comb begin
    s1_rd   = s1_mem_q ? mem_rd_q : s1_reading_q;
    s1_prod = PROD_W'(CHAN_SCALE[s1_ch_q]) * PROD_W'(s1_rd);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      unique case (cmd_q.kind)
        CMD_SAMPLE: begin
          s1_ch_q   <= cmd_q.ch;
          s1_last_q <= 1'b1;
          s1_mem_q  <= 1'b0;
        end
        CMD_REPLAY, CMD_RECORD: begin
          s1_ch_q   <= CH_W'(j_q);
          s1_last_q <= (j_q == JW'(SERVO_COUNT - 1));
          s1_mem_q  <= 1'b1;
        end
        default: begin
          s1_ch_q   <= cmd_q.ch;
          s1_last_q <= 1'b1;
          s1_mem_q  <= 1'b0;
        end
      endcase
      s1_reading_q <= cmd_q.reading;
      s2_ch_q      <= s1_ch_q;
      s2_last_q    <= s1_last_q;
      s2_prod_q    <= s1_prod;
      out_servo_q  <= s2_ch_q;
      out_duty_q   <= div_full(s2_prod_q) + CHAN_OFFSET[s2_ch_q];
      out_last_q   <= s2_last_q;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.servo = out_servo_q;
  assign out_if.duty  = out_duty_q;
  assign out_if.last  = out_last_q;

endmodule

`default_nettype wire

// File: rtl/servo_pose_teach_and_replay.sv
// servo_pose_teach_and_replay: top level of the five-servo teach and replay block
// depends on spq_pkg, spq_if, spq_front, spq_queue, spq_back
//
// channels: in_if takes items (pot sample, record press, tick) with a mode bit;
//   out_if gives one request per duty update (servo, duty, last on the final one);
//   cfg_if writes the dwell length in ticks, always ready; to be written while idle by the user, not enforced
// the front side keeps the mode, record and replay state and issues at most one
//   command per item into a two-entry queue; the back side executes commands
// a sample item passes the queue, the back command register, the s1 and s2 registers and
//   the result register; a replay tick gives its five duties on consecutive cycles unless stalled
// the back sequencer takes a new command only when it is idle; it steps once per servo
//   through a record (five memory writes) or a replay (five memory reads)
// items that cause no command pass in one cycle each while the queue has room
// when the receiver stalls, the result register holds and the duty pipeline,
//   the sequencer and then the queue stop; the input side keeps taking items
//   until the queue fills
// reset clears live readings, recorded flags, replay position and dwell count,
//   and loads the dwell length with 1500; pose memory contents are not cleared,
//   and only those of recorded slots reach a result
`default_nettype none

module servo_pose_teach_and_replay #(
  parameter int SERVO_COUNT = 5,
  parameter int POSE_SLOTS  = 4
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  spq_in_if.sink     in_if,
  spq_cfg_if.sink    cfg_if,
  spq_out_if.source  out_if
);
  import spq_pkg::*;

  // front to queue
  logic     cmd_push;
  spq_cmd_t push_cmd;
  logic     q_full;
  // queue to back
  logic     cmd_pop;
  logic     q_valid;
  spq_cmd_t head_cmd;

  spq_front #(
    .SERVO_COUNT (SERVO_COUNT),
    .POSE_SLOTS  (POSE_SLOTS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .cfg_if  (cfg_if),
    .full_i  (q_full),
    .push_o  (cmd_push),
    .cmd_o   (push_cmd)
  );

  spq_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (cmd_pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  spq_back #(
    .SERVO_COUNT (SERVO_COUNT),
    .POSE_SLOTS  (POSE_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (head_cmd),
    .pop_o       (cmd_pop),
    .out_if      (out_if)
  );

`ifndef NO_ASSERTIONS
  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_push && q_full))
    else $error("command pushed into full queue");

  // replay and record commands name an existing pose slot
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_push && (push_cmd.kind == CMD_REPLAY || push_cmd.kind == CMD_RECORD))
      |-> (int'(push_cmd.slot) < POSE_SLOTS))
    else $error("pose slot out of range");

  // sample commands carry a servo that exists
  a_sample_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_push && push_cmd.kind == CMD_SAMPLE) |-> (int'(push_cmd.ch) < SERVO_COUNT))
    else $error("sample channel out of range");
`endif

endmodule

`default_nettype wire
